/* rtl/core/balance_torque_controller_assert.svh */
// Assertion macros for the balance torque controller RTL
`ifndef BALANCE_TORQUE_CONTROLLER_ASSERT_SVH
`define BALANCE_TORQUE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define BTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define BTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/btc_pkg.sv */
// Types, constants, microcode ROM and helpers for the balance torque controller
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

    localparam int PC_W      = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [PC_W-1:0] UC_IDLE = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_KP       = 3'd0,
        CFG_TILT_KD       = 3'd1,
        CFG_WHEEL_KP      = 3'd2,
        CFG_WHEEL_KD      = 3'd3,
        CFG_SYNC_KP       = 3'd4,
        CFG_SYNC_KD       = 3'd5,
        CFG_SAMPLE_PERIOD = 3'd6,
        CFG_SAMPLE_RATE   = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic signed [31:0] RST_TILT_KP  = -32'sd5296796;
    localparam logic signed [31:0] RST_TILT_KD  = -32'sd1654403;
    localparam logic signed [31:0] RST_WHEEL_KP = -32'sd41449;
    localparam logic signed [31:0] RST_WHEEL_KD = -32'sd157654;
    localparam logic signed [31:0] RST_SYNC_KP  = 32'sd3754936;
    localparam logic signed [31:0] RST_SYNC_KD  = 32'sd187746;
    localparam logic [31:0]        RST_PERIOD   = 32'd4294967;
    localparam logic [19:0]        RST_RATE     = 20'd1000;

    // Saturation bounds on the wide product/sum domain
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    typedef struct packed {
        logic signed [31:0] gyro_rate;
        logic signed [31:0] right_joint_angle;
        logic signed [31:0] left_joint_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] right_torque;
        logic signed [31:0] left_torque;
        logic signed [31:0] tilt_angle_out;
        logic signed [31:0] right_wheel_pos;
        logic signed [31:0] left_wheel_pos;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] tilt_kp;
        logic signed [31:0] tilt_kd;
        logic signed [31:0] wheel_kp;
        logic signed [31:0] wheel_kd;
        logic signed [31:0] sync_kp;
        logic signed [31:0] sync_kd;
        logic [31:0]        sample_period;
        logic [19:0]        sample_rate;
    } t_cfg;

    // Multiplier operand pair selected by a step
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_TILT_INT,
        MUL_RATE_R,
        MUL_RATE_L,
        MUL_TKP,
        MUL_TKD,
        MUL_WKP_R,
        MUL_WKD_R,
        MUL_WKP_L,
        MUL_WKD_L,
        MUL_SKP,
        MUL_SKD
    } t_mul_op;

    // Write-back of the registered product from the previous step
    typedef enum logic [3:0] {
        WB_NONE,
        WB_TILT,
        WB_WHEEL,
        WB_RR,
        WB_LR,
        WB_ACC_C_LOAD,
        WB_ACC_C_ADD,
        WB_ACC_R_LOAD,
        WB_ACC_R_ADD,
        WB_ACC_L_LOAD,
        WB_ACC_L_ADD,
        WB_ACC_L_NEG
    } t_wb_op;

    // Step sequencing
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_FINISH,
        SEQ_JUMP
    } t_seq_op;

    typedef struct packed {
        t_mul_op         mul_op;
        t_wb_op          wb_op;
        t_seq_op         seq_op;
        logic [PC_W-1:0] target;
    } t_ucode;

    // Datapath controls issued by the sequencer
    typedef struct packed {
        t_mul_op mul_op;
        t_wb_op  wb_op;
        logic    load_in;
        logic    load_out;
    } t_dp_ctrl;

    // Control program, one word per step
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        w = '{mul_op: MUL_NONE, wb_op: WB_NONE, seq_op: SEQ_NEXT, target: UC_IDLE};
        case (pc)
            4'd0:  w.seq_op = SEQ_WAIT_IN;
            4'd1:  w.mul_op = MUL_TILT_INT;
            4'd2:  w.wb_op  = WB_TILT;
            4'd3:  begin w.mul_op = MUL_TKP;    w.wb_op = WB_WHEEL;      end
            4'd4:  begin w.mul_op = MUL_RATE_R; w.wb_op = WB_ACC_C_LOAD; end
            4'd5:  begin w.mul_op = MUL_RATE_L; w.wb_op = WB_RR;         end
            4'd6:  begin w.mul_op = MUL_TKD;    w.wb_op = WB_LR;         end
            4'd7:  begin w.mul_op = MUL_WKP_R;  w.wb_op = WB_ACC_C_ADD;  end
            4'd8:  begin w.mul_op = MUL_WKD_R;  w.wb_op = WB_ACC_R_LOAD; end
            4'd9:  begin w.mul_op = MUL_WKP_L;  w.wb_op = WB_ACC_R_ADD;  end
            4'd10: begin w.mul_op = MUL_WKD_L;  w.wb_op = WB_ACC_L_LOAD; end
            4'd11: begin w.mul_op = MUL_SKP;    w.wb_op = WB_ACC_L_ADD;  end
            4'd12: begin w.mul_op = MUL_SKD;    w.wb_op = WB_ACC_L_NEG;  end
            4'd13: w.wb_op  = WB_ACC_L_ADD;
            4'd14: w.seq_op = SEQ_FINISH;
            default: w.seq_op = SEQ_JUMP;
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/balance_torque_controller.sv */
// The control ROM steps once per cycle from request accept, waiting only at the final
// step for a free output slot. A new request is taken only after the single shared 33x33
//   multiplier has run the microcode's eleven products and their write-backs.
// The next request is taken while a finished result still waits in the output register.
// Reset (synchronous, active low): tilt and previous wheel angles cleared, registers to
//   their defaults, sequencer at its idle step, output empty.
`timescale 1ns / 1ps
`default_nettype none

module balance_torque_controller (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  btc_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output btc_pkg::t_out_item              o_out_item,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [btc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [31:0]                     i_cfg_data
);
    import btc_pkg::*;

    t_cfg     cfg;
    t_dp_ctrl ctrl;

    // Register writes are taken in any cycle
    assign o_cfg_ready = 1'b1;

    btc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    btc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctrl      (ctrl)
    );

    btc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_cfg      (cfg),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

    // Checks
    `include "balance_torque_controller_assert.svh"

    `BTC_ASSERT_NXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall,
        "request accepted but sequencer did not go busy")
    `BTC_ASSERT_IMP(a_load_needs_slot, ctrl.load_out, !o_out_valid || !i_out_stall,
        "result loaded over a result not yet taken")
    `BTC_ASSERT_IMP(a_no_in_out_overlap, ctrl.load_in, !ctrl.load_out,
        "request capture and result load in the same step")

endmodule

`default_nettype wire

/* rtl/core/btc_cfg_regs.sv */
// Configuration register file of the balance torque controller
`timescale 1ns / 1ps
`default_nettype none

module btc_cfg_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_wr_en,
    input  wire  [btc_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  wire  [31:0]                     i_wr_data,
    output btc_pkg::t_cfg                   o_cfg
);
    import btc_pkg::*;

    t_cfg r_cfg;

    // Register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_kp       <= RST_TILT_KP;
            r_cfg.tilt_kd       <= RST_TILT_KD;
            r_cfg.wheel_kp      <= RST_WHEEL_KP;
            r_cfg.wheel_kd      <= RST_WHEEL_KD;
            r_cfg.sync_kp       <= RST_SYNC_KP;
            r_cfg.sync_kd       <= RST_SYNC_KD;
            r_cfg.sample_period <= RST_PERIOD;
            r_cfg.sample_rate   <= RST_RATE;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_TILT_KP:       r_cfg.tilt_kp       <= $signed(i_wr_data);
                CFG_TILT_KD:       r_cfg.tilt_kd       <= $signed(i_wr_data);
                CFG_WHEEL_KP:      r_cfg.wheel_kp      <= $signed(i_wr_data);
                CFG_WHEEL_KD:      r_cfg.wheel_kd      <= $signed(i_wr_data);
                CFG_SYNC_KP:       r_cfg.sync_kp       <= $signed(i_wr_data);
                CFG_SYNC_KD:       r_cfg.sync_kd       <= $signed(i_wr_data);
                CFG_SAMPLE_PERIOD: r_cfg.sample_period <= i_wr_data;
                CFG_SAMPLE_RATE:   r_cfg.sample_rate   <= i_wr_data[19:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/btc_seq.sv */
// Microcode sequencer: step counter, control ROM and handshake control
`timescale 1ns / 1ps
`default_nettype none

module btc_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output btc_pkg::t_dp_ctrl    o_ctrl
);
    import btc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_out_valid;
    logic            n_out_valid;
    t_ucode          word;
    logic            out_free;

    assign word     = ucode_rom(r_pc);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next step: advance, wait for a request, wait for a free output slot, or jump to the target
    always_comb begin
        n_pc = r_pc;
        unique case (word.seq_op)
            SEQ_NEXT:    n_pc = r_pc + 1'b1;
            SEQ_WAIT_IN: if (i_in_valid) n_pc = r_pc + 1'b1;
            SEQ_FINISH:  if (out_free) n_pc = word.target;
            SEQ_JUMP:    n_pc = word.target;
            default:     n_pc = UC_IDLE;
        endcase
    end

    // Datapath controls for this step
    always_comb begin
        o_ctrl.mul_op   = word.mul_op;
        o_ctrl.wb_op    = word.wb_op;
        o_ctrl.load_in  = (word.seq_op == SEQ_WAIT_IN) && i_in_valid;
        o_ctrl.load_out = (word.seq_op == SEQ_FINISH) && out_free;
        o_in_stall      = (word.seq_op != SEQ_WAIT_IN);
    end

    // Output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/btc_dp.sv */
// Datapath: shared 33x33 multiplier, rounding write-back, state and accumulators
`timescale 1ns / 1ps
`default_nettype none

module btc_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  btc_pkg::t_dp_ctrl    i_ctrl,
    input  btc_pkg::t_cfg        i_cfg,
    input  btc_pkg::t_in_item    i_in_item,
    output btc_pkg::t_out_item   o_out_item
);
    import btc_pkg::*;

    localparam int ACC_W = 56;

    t_in_item                 r_in;
    t_out_item                r_out;
    logic signed [31:0]       r_tilt;
    logic signed [31:0]       r_prev_r;
    logic signed [31:0]       r_prev_l;
    logic signed [31:0]       r_rw;
    logic signed [31:0]       r_lw;
    logic signed [31:0]       r_rr;
    logic signed [31:0]       r_lr;
    logic signed [65:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc_c;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic signed [ACC_W-1:0]  r_acc_l;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       prod_r32;
    logic signed [65:0]       prod_r16;
    logic signed [65:0]       tilt_sum;
    logic signed [ACC_W-1:0]  p16;

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctrl.mul_op)
            MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_TILT_INT: begin
                mul_a = 33'(r_in.gyro_rate);
                mul_b = $signed({1'b0, i_cfg.sample_period});
            end
            MUL_RATE_R: begin
                mul_a = 33'(r_rw) - 33'(r_prev_r);
                mul_b = $signed({13'd0, i_cfg.sample_rate});
            end
            MUL_RATE_L: begin
                mul_a = 33'(r_lw) - 33'(r_prev_l);
                mul_b = $signed({13'd0, i_cfg.sample_rate});
            end
            MUL_TKP: begin
                mul_a = 33'(i_cfg.tilt_kp);
                mul_b = 33'(r_tilt);
            end
            MUL_TKD: begin
                mul_a = 33'(i_cfg.tilt_kd);
                mul_b = 33'(r_in.gyro_rate);
            end
            MUL_WKP_R: begin
                mul_a = 33'(i_cfg.wheel_kp);
                mul_b = 33'(r_rw);
            end
            MUL_WKD_R: begin
                mul_a = 33'(i_cfg.wheel_kd);
                mul_b = 33'(r_rr);
            end
            MUL_WKP_L: begin
                mul_a = 33'(i_cfg.wheel_kp);
                mul_b = 33'(r_lw);
            end
            MUL_WKD_L: begin
                mul_a = 33'(i_cfg.wheel_kd);
                mul_b = 33'(r_lr);
            end
            MUL_SKP: begin
                mul_a = 33'(i_cfg.sync_kp);
                mul_b = 33'(r_rw) - 33'(r_lw);
            end
            MUL_SKD: begin
                mul_a = 33'(i_cfg.sync_kd);
                mul_b = 33'(r_rr) - 33'(r_lr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounded views of the registered product
    assign prod_r32 = r_prod + 66'sh80000000;
    assign prod_r16 = r_prod + 66'sh8000;
    assign tilt_sum = 66'(r_tilt) + 66'($signed(prod_r32[65:32]));
    assign p16      = ACC_W'($signed(prod_r16[65:16]));

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Input capture, write-back and result staging
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_in <= i_in_item;
        end
        unique case (i_ctrl.wb_op)
            WB_NONE:       r_acc_c <= r_acc_c;
            WB_TILT:       r_acc_c <= r_acc_c;
            WB_WHEEL: begin
                r_rw <= sat32(66'(r_in.right_joint_angle) + 66'(r_tilt));
                r_lw <= sat32(66'(r_in.left_joint_angle) + 66'(r_tilt));
            end
            WB_RR:         r_rr    <= sat32(r_prod);
            WB_LR:         r_lr    <= sat32(r_prod);
            WB_ACC_C_LOAD: r_acc_c <= p16;
            WB_ACC_C_ADD:  r_acc_c <= r_acc_c + p16;
            WB_ACC_R_LOAD: r_acc_r <= r_acc_c + p16;
            WB_ACC_R_ADD:  r_acc_r <= r_acc_r + p16;
            WB_ACC_L_LOAD: r_acc_l <= r_acc_c + p16;
            WB_ACC_L_ADD:  r_acc_l <= r_acc_l + p16;
            WB_ACC_L_NEG:  r_acc_l <= p16 - r_acc_l;
            default:       r_acc_c <= r_acc_c;
        endcase
        if (i_ctrl.load_out) begin
            r_out.right_torque    <= sat32(66'(-r_acc_r));
            r_out.left_torque     <= sat32(66'(r_acc_l));
            r_out.tilt_angle_out  <= r_tilt;
            r_out.right_wheel_pos <= r_rw;
            r_out.left_wheel_pos  <= r_lw;
        end
    end

    // Controller state carried from tick to tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt   <= '0;
            r_prev_r <= '0;
            r_prev_l <= '0;
        end else begin
            if (i_ctrl.wb_op == WB_TILT) begin
                r_tilt <= sat32(tilt_sum);
            end
            if (i_ctrl.load_out) begin
                r_prev_r <= r_rw;
                r_prev_l <= r_lw;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

/* sim/balance_torque_controller_tb.sv */
// Self-checking testbench for the balance torque controller
`timescale 1ns / 1ps

module balance_torque_controller_tb;

    import btc_pkg::*;

    typedef logic signed [79:0] wide_t;

    localparam int NUM_REGS      = 8;
    localparam int NUM_PHASES    = 10;
    localparam int NUM_CORNERS   = 14;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_AFTER    = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic [31:0] Q_MAX    = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;
    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    localparam wide_t S32_HI    = 80'sd2147483647;
    localparam wide_t S32_LO    = -80'sd2147483648;
    localparam wide_t HALF_LSB  = 80'sd32768;
    localparam wide_t HALF_TICK = 80'sd2147483648;

    // Controller predictor plus queue of torques still owed by the block
    class torque_tracker;
        t_cfg               regs;
        logic signed [31:0] tilt;
        logic signed [31:0] prev_right;
        logic signed [31:0] prev_left;
        t_out_item          owed [$];
        int                 mismatches;

        function new();
            regs = '{tilt_kp: RST_TILT_KP, tilt_kd: RST_TILT_KD,
                     wheel_kp: RST_WHEEL_KP, wheel_kd: RST_WHEEL_KD,
                     sync_kp: RST_SYNC_KP, sync_kd: RST_SYNC_KD,
                     sample_period: RST_PERIOD, sample_rate: RST_RATE};
            tilt       = '0;
            prev_right = '0;
            prev_left  = '0;
            mismatches = 0;
        endfunction

        static function wide_t sext(input logic [31:0] v);
            return {{48{v[31]}}, v};
        endfunction

        static function logic signed [31:0] clamp32(input wide_t v);
            if (v > S32_HI) begin
                return 32'sh7fff_ffff;
            end else if (v < S32_LO) begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        // Gain product rounded half up to Q16.16
        static function wide_t qround(input wide_t a, input wide_t b);
            return (a * b + HALF_LSB) >>> 16;
        endfunction

        function wide_t feedback_sum(input wide_t gyro, input wide_t wheel, input wide_t rate);
            return qround(sext(regs.tilt_kp), sext(tilt)) + qround(sext(regs.tilt_kd), gyro)
                 + qround(sext(regs.wheel_kp), wheel) + qround(sext(regs.wheel_kd), rate);
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [31:0] data);
            case (idx)
                CFG_TILT_KP:       regs.tilt_kp = data;
                CFG_TILT_KD:       regs.tilt_kd = data;
                CFG_WHEEL_KP:      regs.wheel_kp = data;
                CFG_WHEEL_KD:      regs.wheel_kd = data;
                CFG_SYNC_KP:       regs.sync_kp = data;
                CFG_SYNC_KD:       regs.sync_kd = data;
                CFG_SAMPLE_PERIOD: regs.sample_period = data;
                CFG_SAMPLE_RATE:   regs.sample_rate = data[19:0];
                default: ;
            endcase
        endfunction

        // Advance the controller state by one tick and queue the torques it yields
        function void note_request(input t_in_item req);
            wide_t     gyro, period, rate;
            wide_t     r_wheel, l_wheel, r_rate, l_rate;
            t_out_item res;
            gyro   = sext(req.gyro_rate);
            period = {48'd0, regs.sample_period};
            rate   = {60'd0, regs.sample_rate};
            tilt   = clamp32(sext(tilt) + ((gyro * period + HALF_TICK) >>> 32));

            r_wheel = sext(clamp32(sext(req.right_joint_angle) + sext(tilt)));
            l_wheel = sext(clamp32(sext(req.left_joint_angle) + sext(tilt)));
            r_rate  = sext(clamp32((r_wheel - sext(prev_right)) * rate));
            l_rate  = sext(clamp32((l_wheel - sext(prev_left)) * rate));
            prev_right = r_wheel[31:0];
            prev_left  = l_wheel[31:0];

            res.right_torque    = clamp32(-feedback_sum(gyro, r_wheel, r_rate));
            res.left_torque     = clamp32(-feedback_sum(gyro, l_wheel, l_rate)
                                  + qround(sext(regs.sync_kp), r_wheel - l_wheel)
                                  + qround(sext(regs.sync_kd), r_rate - l_rate));
            res.tilt_angle_out  = tilt;
            res.right_wheel_pos = r_wheel[31:0];
            res.left_wheel_pos  = l_wheel[31:0];
            owed.push_back(res);
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, field,
                         $signed(want), $signed(got));
                mismatches++;
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                $display("%0t: result with no request pending, expected none got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            compare("right_torque", want.right_torque, got.right_torque);
            compare("left_torque", want.left_torque, got.left_torque);
            compare("tilt_angle_out", want.tilt_angle_out, got.tilt_angle_out);
            compare("right_wheel_pos", want.right_wheel_pos, got.right_wheel_pos);
            compare("left_wheel_pos", want.left_wheel_pos, got.left_wheel_pos);
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_TILT_KP;
    logic [31:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        o_cfg_ready;

    torque_tracker tracker;
    logic [31:0]   cfg_vals [NUM_REGS];
    int            idle_pct     = 20;
    int            rx_burst     = 0;
    int            results_seen = 0;
    logic          hold_rx      = 1'b0;
    int unsigned   cycle_count  = 0;

    balance_torque_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("balance_torque_controller: mismatch");
            $finish;
        end
    end

    // Result side: check accepted results, stall in random bursts
    always @(posedge i_clk) begin : rx_side
        logic stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_item);
            results_seen++;
        end
        if (hold_rx) begin
            stall_next = 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            stall_next = 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
            rx_burst   = $urandom_range(0, 17);
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    // Long receiver hold-off so the block backs up into its request side
    initial begin : backpressure
        wait (results_seen >= HOLD_AFTER);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            11, 12, 13, 14: return $urandom;
            15, 16: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 3))
            0, 1: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2, 3, 4: return $urandom;
            default: return $urandom_range(32'h0010_0000, 32'h0100_0000);
        endcase
    endfunction

    // Upper bits are junk; only the low 20 bits are kept by the block
    function automatic logic [31:0] rand_rate();
        logic [19:0] low;
        case ($urandom_range(0, 9))
            0: low = '0;
            1: low = 20'hf_ffff;
            2, 3, 4: low = 20'($urandom);
            default: low = 20'($urandom_range(1, 2000));
        endcase
        return {12'($urandom), low};
    endfunction

    function automatic t_in_item random_req();
        t_in_item r;
        r.gyro_rate         = rand_q();
        r.right_joint_angle = rand_q();
        r.left_joint_angle  = rand_q();
        return r;
    endfunction

    // Directed requests: first tick, zeros, field extremes and mixed signs
    function automatic t_in_item corner_req(input int k);
        t_in_item r;
        case (k)
            0:  r = '{Q_ONE, 32'h0000_8000, 32'hffff_8000};
            1:  r = '{32'h0, 32'h0, 32'h0};
            2:  r = '{Q_MAX, Q_MAX, Q_MAX};
            3:  r = '{Q_MAX, Q_MAX, Q_MAX};
            4:  r = '{Q_MIN, Q_MIN, Q_MIN};
            5:  r = '{Q_MIN, Q_MIN, Q_MIN};
            6:  r = '{Q_MIN, Q_MAX, Q_MIN};
            7:  r = '{Q_MAX, Q_MIN, Q_MAX};
            8:  r = '{ALL_ONES, 32'h1, ALL_ONES};
            9:  r = '{32'h1, ALL_ONES, 32'h1};
            10: r = '{32'h0, Q_MAX, Q_MIN};
            11: r = '{32'h0, Q_MIN, Q_MAX};
            12: r = '{32'h0, 32'h0, 32'h0};
            default: r = '{32'hfffe_0000, 32'h0002_0000, 32'h0003_0000};
        endcase
        return r;
    endfunction

    // Register settings per phase: both extremes, smallest tick, defaults, random
    task automatic pick_regs(input int phase);
        case (phase)
            1: begin
                for (int k = 0; k < NUM_REGS; k++) cfg_vals[k] = Q_MAX;
                cfg_vals[CFG_SAMPLE_PERIOD] = ALL_ONES;
                cfg_vals[CFG_SAMPLE_RATE]   = ALL_ONES;
            end
            2: begin
                for (int k = 0; k < NUM_REGS; k++) cfg_vals[k] = Q_MIN;
                cfg_vals[CFG_SAMPLE_PERIOD] = '0;
                cfg_vals[CFG_SAMPLE_RATE]   = 32'hfff0_0000;
            end
            3: begin
                for (int k = 0; k < NUM_REGS; k++) cfg_vals[k] = rand_gain();
                cfg_vals[CFG_SAMPLE_PERIOD] = 32'h1;
                cfg_vals[CFG_SAMPLE_RATE]   = 32'h1;
            end
            NUM_PHASES - 1: begin
                cfg_vals[CFG_TILT_KP]       = RST_TILT_KP;
                cfg_vals[CFG_TILT_KD]       = RST_TILT_KD;
                cfg_vals[CFG_WHEEL_KP]      = RST_WHEEL_KP;
                cfg_vals[CFG_WHEEL_KD]      = RST_WHEEL_KD;
                cfg_vals[CFG_SYNC_KP]       = RST_SYNC_KP;
                cfg_vals[CFG_SYNC_KD]       = RST_SYNC_KD;
                cfg_vals[CFG_SAMPLE_PERIOD] = RST_PERIOD;
                cfg_vals[CFG_SAMPLE_RATE]   = {12'd0, RST_RATE};
            end
            default: begin
                for (int k = 0; k < NUM_REGS; k++) cfg_vals[k] = rand_gain();
                cfg_vals[CFG_SAMPLE_PERIOD] = rand_period();
                cfg_vals[CFG_SAMPLE_RATE]   = rand_rate();
            end
        endcase
    endtask

    // Write every register back to back; valid drops only after the last one
    task automatic write_regs();
        for (int k = 0; k < NUM_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= cfg_vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(t_cfg_idx'(k), cfg_vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one request and hold it until taken, then maybe leave a gap
    task automatic send_request(input t_in_item req);
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(req);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Phases: reset defaults with directed requests, then a new setting per phase
    initial begin : stimulus
        int n_items;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                pick_regs(p);
                write_regs();
            end
            case (p)
                0: begin
                    n_items  = 20;
                    idle_pct = 20;
                end
                1, 2: begin
                    n_items  = 110;
                    idle_pct = 30;
                end
                3: begin
                    n_items  = 150;
                    idle_pct = 0;
                end
                NUM_PHASES - 1: begin
                    n_items  = 160;
                    idle_pct = 0;
                end
                default: begin
                    n_items  = 220;
                    idle_pct = (p * 7) % 50 + 5;
                end
            endcase
            for (int k = 0; k < n_items; k++) begin
                if (p == 0 && k < NUM_CORNERS) begin
                    send_request(corner_req(k));
                end else begin
                    send_request(random_req());
                end
            end
            i_in_valid <= 1'b0;
            drain();
        end
        if (tracker.mismatches == 0) begin
            $display("balance_torque_controller: match");
        end else begin
            $display("balance_torque_controller: mismatch");
        end
        $finish;
    end

endmodule

/* balance_torque_controller.f */
+incdir+rtl/core
rtl/core/btc_pkg.sv
rtl/core/btc_cfg_regs.sv
rtl/core/btc_seq.sv
rtl/core/btc_dp.sv
rtl/core/balance_torque_controller.sv
sim/balance_torque_controller_tb.sv
